[design/crw_pkg.sv]
// Package for the command record walker: command codes, reply codes, ranks.
// Used by every module of the walker; depends on nothing.
package crw_pkg;

    localparam logic [31:0] CMD_TERMINATE   = 32'h1;
    localparam logic [31:0] CMD_STREAM_INFO = 32'h190;
    localparam logic [31:0] CMD_SET_ADDR    = 32'hc8;
    localparam logic [31:0] CMD_CHUNK       = 32'hc9;

    localparam logic [3:0] CODE_NONE       = 4'd0;
    localparam logic [3:0] CODE_STREAM_OP  = 4'd2;
    localparam logic [3:0] CODE_SEND_DONE  = 4'd13;
    localparam logic [3:0] CODE_TERMINATED = 4'd14;

    localparam logic [32:0] HEADER_BYTES = 33'd8;

    typedef enum logic [1:0] {
        RANK_NONE   = 2'd0,
        RANK_SEND   = 2'd1,
        RANK_STREAM = 2'd2,
        RANK_TERM   = 2'd3
    } rank_t;

    typedef enum logic [2:0] {
        KIND_OTHER  = 3'd0,
        KIND_STREAM = 3'd1,
        KIND_TERM   = 3'd2,
        KIND_SET    = 3'd3,
        KIND_CHUNK  = 3'd4
    } kind_t;

    // One classified event from the front part.
    typedef struct packed {
        logic        rec_done;   // a header completed and the record is valid
        kind_t       kind;
        logic        set_collect; // set-address record with len >= 4
        logic [31:0] len;
        logic [31:0] addr;        // payload address for stream-op
        logic        addr_done;   // fourth destination byte arrived
        logic [31:0] addr_value;
        logic        last;
    } event_t;

endpackage

[design/crw_front.sv]
// Front part of the walker: tracks byte offset, headers and payloads, and
// classifies each item into one event. Depends on crw_pkg.
module crw_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         flush_base,
    input  logic [31:0]         flush_size,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                last_byte,
    output logic                ev_valid,
    input  logic                ev_stall,
    output crw_pkg::event_t     ev
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_STOPPED = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] offset_reg, offset_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [55:0] hdr_reg, hdr_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] left_reg, left_next;
    logic        collect_reg, collect_next;
    logic [1:0]  acnt_reg, acnt_next;
    logic [23:0] asm_reg, asm_next;
    logic                ev_valid_reg;
    crw_pkg::event_t     ev_reg, ev_next;

    logic        take;
    logic [31:0] cmd_w, len_w;
    logic [32:0] room;

    assign in_stall = ev_valid_reg && ev_stall;
    assign take     = in_valid && !in_stall;
    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

    assign cmd_w = hdr_reg[31:0];
    assign len_w = {data_byte, hdr_reg[55:32]};
    assign room  = {1'b0, flush_size} - {1'b0, start_reg} - crw_pkg::HEADER_BYTES;

    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        hdr_cnt_next = hdr_cnt_reg;
        hdr_next     = hdr_reg;
        start_next   = start_reg;
        left_next    = left_reg;
        collect_next = collect_reg;
        acnt_next    = acnt_reg;
        asm_next     = asm_reg;
        ev_next             = '0;
        ev_next.kind        = crw_pkg::KIND_OTHER;
        ev_next.last        = last_byte;
        ev_next.len         = len_w;
        ev_next.addr        = flush_base + start_reg + 32'd8;
        ev_next.addr_value  = {data_byte, asm_reg};
        if (has_byte)
        begin
            offset_next = offset_reg + 32'd1;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_cnt_reg == 3'd0
                        && ({1'b0, offset_reg} + crw_pkg::HEADER_BYTES) > {1'b0, flush_size})
                    begin
                        phase_next = PH_STOPPED;
                    end
                    else
                    begin
                        if (hdr_cnt_reg == 3'd0)
                        begin
                            start_next = offset_reg;
                        end
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                        if (hdr_cnt_reg != 3'd7)
                        begin
                            hdr_next = hdr_reg;
                            hdr_next[hdr_cnt_reg*8 +: 8] = data_byte;
                        end
                        else
                        begin
                            // Room is computed modulo 2^32, as the walk defines it.
                            if (len_w > room[31:0])
                            begin
                                phase_next = PH_STOPPED;
                            end
                            else
                            begin
                                ev_next.rec_done = 1'b1;
                                collect_next = 1'b0;
                                priority if (cmd_w == crw_pkg::CMD_STREAM_INFO)
                                    ev_next.kind = crw_pkg::KIND_STREAM;
                                else if (cmd_w == crw_pkg::CMD_TERMINATE)
                                    ev_next.kind = crw_pkg::KIND_TERM;
                                else if (cmd_w == crw_pkg::CMD_SET_ADDR)
                                begin
                                    ev_next.kind = crw_pkg::KIND_SET;
                                    collect_next = (len_w >= 32'd4);
                                    acnt_next    = 2'd0;
                                    asm_next     = '0;
                                end
                                else if (cmd_w == crw_pkg::CMD_CHUNK)
                                    ev_next.kind = crw_pkg::KIND_CHUNK;
                                else
                                    ev_next.kind = crw_pkg::KIND_OTHER;
                                left_next  = len_w;
                                phase_next = (len_w == 32'd0) ? PH_HEADER : PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (collect_reg)
                    begin
                        acnt_next = acnt_reg + 2'd1;
                        if (acnt_reg == 2'd3)
                        begin
                            ev_next.addr_done = 1'b1;
                            collect_next = 1'b0;
                        end
                        else
                        begin
                            asm_next = asm_reg;
                            asm_next[acnt_reg*8 +: 8] = data_byte;
                        end
                    end
                    left_next = left_reg - 32'd1;
                    if (left_reg == 32'd1)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_STOPPED:
                begin
                end
                default:
                begin
                end
            endcase
        end
        if (last_byte)
        begin
            phase_next   = PH_HEADER;
            offset_next  = '0;
            hdr_cnt_next = '0;
            collect_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            offset_reg   <= '0;
            hdr_cnt_reg  <= '0;
            collect_reg  <= 1'b0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                ev_valid_reg <= take;
            end
            if (take)
            begin
                phase_reg   <= phase_next;
                offset_reg  <= offset_next;
                hdr_cnt_reg <= hdr_cnt_next;
                collect_reg <= collect_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hdr_reg   <= hdr_next;
            start_reg <= start_next;
            left_reg  <= left_next;
            acnt_reg  <= acnt_next;
            asm_reg   <= asm_next;
            ev_reg    <= ev_next;
        end
    end

endmodule

[design/crw_queue.sv]
// Two-entry queue between the front and back parts of the walker.
// Depends on crw_pkg for the event type.
module crw_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_stall,
    input  crw_pkg::event_t wr_data,
    output logic            rd_valid,
    input  logic            rd_stall,
    output crw_pkg::event_t rd_data
);

    crw_pkg::event_t mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem[rp_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_data;
    end

endmodule

[design/crw_back.sv]
// Back part of the walker: counters, destination pointer, best reply and
// the result register. Depends on crw_pkg.
module crw_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            chunk_ack_enable,
    input  logic            ev_valid,
    output logic            ev_stall,
    input  crw_pkg::event_t ev,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            reply_valid,
    output logic [3:0]      reply_code,
    output logic [31:0]     reply_data,
    output logic [31:0]     reply_len,
    output logic [31:0]     records_seen,
    output logic [31:0]     terminate_count,
    output logic [31:0]     stream_info_count,
    output logic [31:0]     replies_sent,
    output logic [31:0]     unanswered_count,
    output logic [31:0]     set_addr_count,
    output logic [31:0]     chunk_count,
    output logic [31:0]     upload_dest
);

    crw_pkg::rank_t rank_reg, rank_next;
    logic [3:0]  code_reg, code_next;
    logic [31:0] bdata_reg, bdata_next, blen_reg, blen_next;
    logic [31:0] rec_reg, term_reg, strm_reg, rep_reg, unans_reg, set_reg, chk_reg, dest_reg;
    logic [31:0] rec_next, term_next, strm_next, rep_next, unans_next, set_next, chk_next;
    logic [31:0] dest_next;
    logic        ovalid_reg;
    logic        take, emit, has_reply;

    assign ev_stall  = ovalid_reg && out_stall;
    assign take      = ev_valid && !ev_stall;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        rank_next  = rank_reg;
        code_next  = code_reg;
        bdata_next = bdata_reg;
        blen_next  = blen_reg;
        rec_next   = rec_reg;
        term_next  = term_reg;
        strm_next  = strm_reg;
        rep_next   = rep_reg;
        unans_next = unans_reg;
        set_next   = set_reg;
        chk_next   = chk_reg;
        dest_next  = dest_reg;
        if (ev.rec_done)
        begin
            rec_next = rec_reg + 32'd1;
            unique case (ev.kind)
                crw_pkg::KIND_STREAM:
                begin
                    strm_next = strm_reg + 32'd1;
                    if (rank_reg != crw_pkg::RANK_NONE)
                        unans_next = unans_reg + 32'd1;
                    if (rank_reg != crw_pkg::RANK_STREAM && rank_reg != crw_pkg::RANK_TERM)
                    begin
                        rank_next  = crw_pkg::RANK_STREAM;
                        code_next  = crw_pkg::CODE_STREAM_OP;
                        bdata_next = ev.addr;
                        blen_next  = ev.len;
                    end
                end
                crw_pkg::KIND_TERM:
                begin
                    term_next = term_reg + 32'd1;
                    if (rank_reg != crw_pkg::RANK_NONE)
                        unans_next = unans_reg + 32'd1;
                    rank_next  = crw_pkg::RANK_TERM;
                    code_next  = crw_pkg::CODE_TERMINATED;
                    bdata_next = '0;
                    blen_next  = '0;
                end
                crw_pkg::KIND_CHUNK:
                begin
                    chk_next  = chk_reg + 32'd1;
                    dest_next = dest_reg + ev.len;
                    if (chunk_ack_enable)
                    begin
                        if (rank_reg != crw_pkg::RANK_NONE)
                            unans_next = unans_reg + 32'd1;
                        else
                        begin
                            rank_next  = crw_pkg::RANK_SEND;
                            code_next  = crw_pkg::CODE_SEND_DONE;
                            bdata_next = '0;
                            blen_next  = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (ev.addr_done)
        begin
            dest_next = ev.addr_value;
            set_next  = set_reg + 32'd1;
        end
    end

    assign emit      = take && ev.last;
    assign has_reply = (rank_next != crw_pkg::RANK_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg   <= crw_pkg::RANK_NONE;
            code_reg   <= '0;
            bdata_reg  <= '0;
            blen_reg   <= '0;
            rec_reg    <= '0;
            term_reg   <= '0;
            strm_reg   <= '0;
            rep_reg    <= '0;
            unans_reg  <= '0;
            set_reg    <= '0;
            chk_reg    <= '0;
            dest_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (!ev_stall)
                ovalid_reg <= emit;
            if (take)
            begin
                rec_reg   <= rec_next;
                term_reg  <= term_next;
                strm_reg  <= strm_next;
                unans_reg <= unans_next;
                set_reg   <= set_next;
                chk_reg   <= chk_next;
                dest_reg  <= dest_next;
                rep_reg   <= rep_next + {31'd0, emit && has_reply};
                if (ev.last)
                begin
                    rank_reg  <= crw_pkg::RANK_NONE;
                    code_reg  <= '0;
                    bdata_reg <= '0;
                    blen_reg  <= '0;
                end
                else
                begin
                    rank_reg  <= rank_next;
                    code_reg  <= code_next;
                    bdata_reg <= bdata_next;
                    blen_reg  <= blen_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            reply_valid       <= has_reply;
            reply_code        <= has_reply ? code_next : crw_pkg::CODE_NONE;
            reply_data        <= has_reply ? bdata_next : 32'd0;
            reply_len         <= has_reply ? blen_next : 32'd0;
            records_seen      <= rec_next;
            terminate_count   <= term_next;
            stream_info_count <= strm_next;
            replies_sent      <= rep_next + {31'd0, has_reply};
            unanswered_count  <= unans_next;
            set_addr_count    <= set_next;
            chunk_count       <= chk_next;
            upload_dest       <= dest_next;
        end
    end

endmodule

[design/command_record_walker_top.sv]
// Top level of the command record walker: front, queue, back and the config bit.
// Depends on crw_pkg, crw_front, crw_queue and crw_back.
//
//   channel  | handshake            | payload
//   input    | in_valid / in_stall  | flush_base flush_size data_byte has_byte last_byte
//   output   | out_valid / out_stall| reply_* and counter snapshot, upload_dest
//   config   | cfg_we               | cfg_data (chunk_ack_enable)
//
// One item per cycle is accepted while in_stall is low; the result for a flush passes
// through the front register, a queue entry and the result register after the edge that
// takes its last item. Reset clears all counters, the destination pointer and the walk
// state, and sets chunk acknowledge on. A stalled output fills the two-entry queue and
// the front register, then stalls the input.
module command_record_walker_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] flush_base,
    input  logic [31:0] flush_size,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        reply_valid,
    output logic [3:0]  reply_code,
    output logic [31:0] reply_data,
    output logic [31:0] reply_len,
    output logic [31:0] records_seen,
    output logic [31:0] terminate_count,
    output logic [31:0] stream_info_count,
    output logic [31:0] replies_sent,
    output logic [31:0] unanswered_count,
    output logic [31:0] set_addr_count,
    output logic [31:0] chunk_count,
    output logic [31:0] upload_dest
);

    logic            ack_en_reg;
    logic            f_valid, f_stall, q_valid, q_stall;
    crw_pkg::event_t f_ev, q_ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ack_en_reg <= 1'b1;
        else if (cfg_we)
            ack_en_reg <= cfg_data;
    end

    crw_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .flush_base(flush_base), .flush_size(flush_size), .data_byte(data_byte),
        .has_byte(has_byte), .last_byte(last_byte),
        .ev_valid(f_valid), .ev_stall(f_stall), .ev(f_ev)
    );

    crw_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_ev),
        .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_ev)
    );

    crw_back u_back
    (
        .clk(clk), .rst_n(rst_n), .chunk_ack_enable(ack_en_reg),
        .ev_valid(q_valid), .ev_stall(q_stall), .ev(q_ev),
        .out_valid(out_valid), .out_stall(out_stall),
        .reply_valid(reply_valid), .reply_code(reply_code),
        .reply_data(reply_data), .reply_len(reply_len),
        .records_seen(records_seen), .terminate_count(terminate_count),
        .stream_info_count(stream_info_count), .replies_sent(replies_sent),
        .unanswered_count(unanswered_count), .set_addr_count(set_addr_count),
        .chunk_count(chunk_count), .upload_dest(upload_dest)
    );

endmodule

[design/crw_checker.sv]
// Port-level checker for the command record walker, bound to the top level.
// Depends on crw_pkg and command_record_walker_top.
module crw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        reply_valid,
    input logic [3:0]  reply_code,
    input logic [31:0] reply_data
);

    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(reply_code))
        else $error("stalled result changed");

    ap_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_valid |-> reply_code == crw_pkg::CODE_STREAM_OP
            || reply_code == crw_pkg::CODE_SEND_DONE
            || reply_code == crw_pkg::CODE_TERMINATED)
        else $error("bad reply code");

    ap_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reply_valid |-> reply_code == crw_pkg::CODE_NONE && reply_data == 32'd0)
        else $error("empty reply carries data");

    ap_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_code != crw_pkg::CODE_STREAM_OP |-> reply_data == 32'd0)
        else $error("reply data without stream op");

endmodule

bind command_record_walker_top crw_checker u_crw_checker
(
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .reply_valid(reply_valid), .reply_code(reply_code), .reply_data(reply_data)
);

[bench/tb_top.sv]
// Testbench for the command record walker: directed flushes, then random flushes,
// all checked against a cycle-free predictor written here. Depends on crw_pkg and
// command_record_walker_top.
module tb_top;

    typedef enum logic [1:0] {WALK_HEADER, WALK_PAYLOAD, WALK_STOPPED} walk_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  code;
        logic [31:0] data;
        logic [31:0] len;
        logic [31:0] records;
        logic [31:0] terms;
        logic [31:0] streams;
        logic [31:0] replies;
        logic [31:0] unanswered;
        logic [31:0] set_addrs;
        logic [31:0] chunks;
        logic [31:0] dest;
    } snapshot_t;

    typedef struct {
        bit          empty;
        logic [31:0] cmd;
        logic [31:0] len;
        int          npay;
        logic [31:0] base;
        bit          fix_size;
        logic [31:0] size;
        bit          ack;
        bit          typed;
    } flush_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] flush_base;
    logic [31:0] flush_size;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    snapshot_t   got;

    command_record_walker_top u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .flush_base(flush_base),
        .flush_size(flush_size), .data_byte(data_byte), .has_byte(has_byte),
        .last_byte(last_byte), .out_valid(out_valid), .out_stall(out_stall),
        .reply_valid(got.valid), .reply_code(got.code), .reply_data(got.data),
        .reply_len(got.len), .records_seen(got.records), .terminate_count(got.terms),
        .stream_info_count(got.streams), .replies_sent(got.replies),
        .unanswered_count(got.unanswered), .set_addr_count(got.set_addrs),
        .chunk_count(got.chunks), .upload_dest(got.dest)
    );

    // Walker state kept by the predictor.
    walk_t           walk_state;
    logic [31:0]     walk_pos;
    int              hdr_bytes;
    logic [63:0]     hdr_acc;
    logic [31:0]     cur_start;
    logic [31:0]     pay_left;
    logic [31:0]     dest_acc;
    int              dest_cnt;
    bit              dest_collect;
    crw_pkg::rank_t  best_rank;
    logic [3:0]      best_code;
    logic [31:0]     best_addr;
    logic [31:0]     best_size;
    snapshot_t       tally;
    bit              ack_en;

    snapshot_t   snapshot_q[$];
    logic [7:0]  flush_q[$];
    int          errors;
    int          mismatches;
    int          items_sent;
    int          cycles;
    bit          calm;
    bit          press_req;
    bit          press_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = 1'b1;
            #1 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1000000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom % 100;
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic clear_walk();
        walk_state   = WALK_HEADER;
        walk_pos     = '0;
        hdr_bytes    = 0;
        hdr_acc      = '0;
        cur_start    = '0;
        pay_left     = '0;
        dest_acc     = '0;
        dest_cnt     = 0;
        dest_collect = 0;
        best_rank    = crw_pkg::RANK_NONE;
        best_code    = crw_pkg::CODE_NONE;
        best_addr    = '0;
        best_size    = '0;
    endtask

    task automatic take_reply(crw_pkg::rank_t r, logic [3:0] c, logic [31:0] d,
                              logic [31:0] l);
        best_rank = r;
        best_code = c;
        best_addr = d;
        best_size = l;
    endtask

    task automatic count_record(logic [31:0] cmd, logic [31:0] len, logic [31:0] base);
        tally.records++;
        if (cmd == crw_pkg::CMD_STREAM_INFO)
        begin
            tally.streams++;
            if (best_rank != crw_pkg::RANK_NONE)
                tally.unanswered++;
            if (best_rank < crw_pkg::RANK_STREAM)
                take_reply(crw_pkg::RANK_STREAM, crw_pkg::CODE_STREAM_OP,
                           base + cur_start + 32'd8, len);
        end
        else if (cmd == crw_pkg::CMD_TERMINATE)
        begin
            tally.terms++;
            if (best_rank != crw_pkg::RANK_NONE)
                tally.unanswered++;
            take_reply(crw_pkg::RANK_TERM, crw_pkg::CODE_TERMINATED, '0, '0);
        end
        else if (cmd == crw_pkg::CMD_SET_ADDR)
        begin
            dest_collect = (len >= 32'd4);
            dest_cnt = 0;
            dest_acc = '0;
        end
        else if (cmd == crw_pkg::CMD_CHUNK)
        begin
            tally.chunks++;
            tally.dest += len;
            if (ack_en)
            begin
                if (best_rank != crw_pkg::RANK_NONE)
                    tally.unanswered++;
                else
                    take_reply(crw_pkg::RANK_SEND, crw_pkg::CODE_SEND_DONE, '0, '0);
            end
        end
    endtask

    task automatic walk_one(logic [7:0] b, logic [31:0] base, logic [31:0] size);
        logic [31:0] p;
        logic [31:0] cmd;
        logic [31:0] len;
        p = walk_pos;
        walk_pos = p + 1;
        if (walk_state == WALK_HEADER)
        begin
            if (hdr_bytes == 0)
            begin
                if ({32'd0, p} + 64'd8 > {32'd0, size})
                begin
                    walk_state = WALK_STOPPED;
                    return;
                end
                cur_start = p;
                hdr_acc = '0;
            end
            hdr_acc[8*hdr_bytes +: 8] = b;
            hdr_bytes++;
            if (hdr_bytes == 8)
            begin
                cmd = hdr_acc[31:0];
                len = hdr_acc[63:32];
                hdr_bytes = 0;
                if (len > size - cur_start - 32'd8)
                begin
                    walk_state = WALK_STOPPED;
                    return;
                end
                dest_collect = 0;
                count_record(cmd, len, base);
                pay_left = len;
                walk_state = (len == 0) ? WALK_HEADER : WALK_PAYLOAD;
            end
        end
        else if (walk_state == WALK_PAYLOAD)
        begin
            if (dest_collect && dest_cnt < 4)
            begin
                dest_acc[8*dest_cnt +: 8] = b;
                dest_cnt++;
                if (dest_cnt == 4)
                begin
                    tally.dest = dest_acc;
                    tally.set_addrs++;
                    dest_collect = 0;
                end
            end
            pay_left--;
            if (pay_left == 0)
                walk_state = WALK_HEADER;
        end
    endtask

    // Updates the predictor for one accepted item; returns 1 when a result is due.
    task automatic predict_item(logic [31:0] base, logic [31:0] size, logic [7:0] b,
                                logic has, logic last, output bit due, output snapshot_t s);
        due = 0;
        s = '0;
        if (has)
            walk_one(b, base, size);
        if (!last)
            return;
        due = 1;
        if (best_rank != crw_pkg::RANK_NONE)
            tally.replies++;
        s = tally;
        s.valid = (best_rank != crw_pkg::RANK_NONE);
        if (s.valid)
        begin
            s.code = best_code;
            s.data = best_addr;
            s.len  = best_size;
        end
        clear_walk();
    endtask

    // Offers one item and returns at the edge where it is taken.
    task automatic send_item(logic [31:0] base, logic [31:0] size, logic [7:0] b,
                             logic has, logic last, bit typed, snapshot_t typed_s);
        int g;
        bit due;
        snapshot_t s;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        flush_base <= base;
        flush_size <= size;
        data_byte  <= b;
        has_byte   <= has;
        last_byte  <= last;
        in_valid   <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_item(base, size, b, has, last, due, s);
        if (due)
            snapshot_q.insert(snapshot_q.size(), typed ? typed_s : s);
        if (has || last)
            items_sent++;
        if (items_sent >= 200)
            press_req = 1;
    endtask

    task automatic send_flush(logic [31:0] base, logic [31:0] size, bit typed,
                              snapshot_t typed_s);
        int n;
        n = flush_q.size();
        if (n == 0)
        begin
            send_item(base, size, 8'($urandom), 1'b0, 1'b1, typed, typed_s);
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom % 20 == 0)
                send_item(base, size, 8'($urandom), 1'b0, 1'b0, 0, '0);
            send_item(base, size, flush_q[i], 1'b1, i == n - 1, typed, typed_s);
        end
        flush_q.delete();
    endtask

    task automatic add_record(logic [31:0] cmd, logic [31:0] len, int npay);
        for (int i = 0; i < 4; i++)
            flush_q.insert(flush_q.size(), cmd[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            flush_q.insert(flush_q.size(), len[8*i +: 8]);
        for (int i = 0; i < npay; i++)
            flush_q.insert(flush_q.size(), 8'($urandom));
    endtask

    // The block is idle only once every result is out and the items that caused none
    // have drained.
    task automatic write_ack(bit v);
        in_valid <= 1'b0;
        while (snapshot_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        ack_en = v;
    endtask

    task automatic report(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            errors++;
            if (mismatches < 10)
                $display("mismatch %s: expected %h, got %h", name, e, a);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        snapshot_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (snapshot_q.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected result item");
                mismatches++;
            end
            else
            begin
                e = snapshot_q.pop_front();
                report("reply_valid", e.valid, got.valid);
                report("reply_code", e.code, got.code);
                report("reply_data", e.data, got.data);
                report("reply_len", e.len, got.len);
                report("records_seen", e.records, got.records);
                report("terminate_count", e.terms, got.terms);
                report("stream_info_count", e.streams, got.streams);
                report("replies_sent", e.replies, got.replies);
                report("unanswered_count", e.unanswered, got.unanswered);
                report("set_addr_count", e.set_addrs, got.set_addrs);
                report("chunk_count", e.chunks, got.chunks);
                report("upload_dest", e.dest, got.dest);
            end
        end
    end

    // Receiver: random stall runs, plus one long hold-off that backs the block up.
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (press_req && !press_done)
            begin
                press_done = 1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            else if (calm || $urandom % 3 != 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 15)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (gap_len()) @(posedge clk);
            end
        end
    end

    flush_row_t rows[15];

    initial
    begin
        logic [31:0] base;
        logic [31:0] size;
        logic [31:0] cmd;
        logic [31:0] len;
        int          nrec;
        int          npay;
        int          k;
        bit          stop;

        rows[0]  = '{1, 0, 0, 0, 32'h0, 0, 0, 1, 1};
        rows[1]  = '{0, crw_pkg::CMD_TERMINATE, 0, 0, 32'h0, 0, 0, 1, 0};
        rows[2]  = '{0, crw_pkg::CMD_STREAM_INFO, 4, 4, 32'hffff_ffff, 0, 0, 1, 0};
        rows[3]  = '{0, crw_pkg::CMD_STREAM_INFO, 0, 0, 32'h1234_5678, 0, 0, 1, 0};
        rows[4]  = '{0, crw_pkg::CMD_SET_ADDR, 4, 4, 32'h0, 0, 0, 1, 0};
        rows[5]  = '{0, crw_pkg::CMD_SET_ADDR, 2, 2, 32'h0, 0, 0, 1, 0};
        rows[6]  = '{0, crw_pkg::CMD_SET_ADDR, 6, 6, 32'h0, 0, 0, 1, 0};
        rows[7]  = '{0, crw_pkg::CMD_CHUNK, 3, 3, 32'h0, 0, 0, 1, 0};
        rows[8]  = '{0, crw_pkg::CMD_CHUNK, 32'hffff_fff7, 2, 32'h0, 1, 32'hffff_ffff,
                     1, 0};
        rows[9]  = '{0, 32'hffff_ffff, 0, 0, 32'h0, 0, 0, 1, 0};
        rows[10] = '{0, crw_pkg::CMD_STREAM_INFO, 0, 0, 32'h0, 1, 7, 1, 0};
        rows[11] = '{0, crw_pkg::CMD_STREAM_INFO, 5, 5, 32'h0, 1, 12, 1, 0};
        rows[12] = '{0, crw_pkg::CMD_CHUNK, 1, 1, 32'h0, 0, 0, 0, 0};
        rows[13] = '{0, crw_pkg::CMD_TERMINATE, 0, 0, 32'h0, 0, 0, 0, 0};
        rows[14] = '{0, crw_pkg::CMD_CHUNK, 2, 2, 32'h0, 0, 0, 1, 0};

        errors = 0;
        mismatches = 0;
        items_sent = 0;
        cycles = 0;
        calm = 0;
        press_req = 0;
        press_done = 0;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_data   <= 1'b0;
        in_valid   <= 1'b0;
        flush_base <= '0;
        flush_size <= '0;
        data_byte  <= '0;
        has_byte   <= 1'b0;
        last_byte  <= 1'b0;
        clear_walk();
        tally = '0;
        ack_en = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].ack != ack_en)
                write_ack(rows[i].ack);
            if (!rows[i].empty)
                add_record(rows[i].cmd, rows[i].len, rows[i].npay);
            size = rows[i].fix_size ? rows[i].size : 8 + rows[i].npay;
            // Right after reset an empty flush reports nothing and all counters zero.
            send_flush(rows[i].base, size, rows[i].typed, '0);
        end

        for (int f = 0; items_sent < 450; f++)
        begin
            if (f % 10 == 9)
                write_ack(1'($urandom_range(0, 1)));
            calm = ($urandom % 6 == 0);
            base = $urandom;
            nrec = $urandom_range(0, 4);
            stop = 0;
            for (int r = 0; r < nrec && !stop; r++)
            begin
                k = $urandom % 10;
                case (k)
                    0, 1: cmd = crw_pkg::CMD_TERMINATE;
                    2, 3: cmd = crw_pkg::CMD_STREAM_INFO;
                    4, 5: cmd = crw_pkg::CMD_SET_ADDR;
                    6, 7: cmd = crw_pkg::CMD_CHUNK;
                    8: cmd = $urandom;
                    default: cmd = $urandom % 512;
                endcase
                k = $urandom % 10;
                if (k < 8)
                    len = $urandom_range(0, 6);
                else if (k == 8)
                    len = $urandom_range(7, 20);
                else
                    len = $urandom;
                npay = (len > 20) ? $urandom_range(0, 3) : len;
                stop = (len > 20);
                add_record(cmd, len, npay);
            end
            size = flush_q.size();
            k = $urandom % 20;
            if (k < 2)
                size = size - $urandom_range(1, 9);
            else if (k < 4)
                size = size + $urandom_range(1, 9);
            else if (k == 4)
                size = $urandom;
            if ($urandom % 10 == 0 && flush_q.size() > 0)
                flush_q = flush_q[0:$urandom_range(0, flush_q.size() - 1)];
            send_flush(base, size, 0, '0);
        end
        in_valid <= 1'b0;

        while (snapshot_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/crw_pkg.sv
design/crw_front.sv
design/crw_queue.sv
design/crw_back.sv
design/command_record_walker_top.sv
design/crw_checker.sv
bench/tb_top.sv
